/* hdl/dpmc_pkg.sv */
// dpmc_pkg: shared types, constants and the 3x3 median network of the
// defect pixel median correction core. No dependencies.
package dpmc_pkg;

  localparam int PIX_W          = 8;
  localparam int COORD_W        = 11;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 12;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [PIX_W-1:0]      RST_DEAD_LEVEL   = 8'd0;
  localparam logic [PIX_W-1:0]      RST_HOT_LEVEL    = 8'd255;
  localparam logic [PIX_W-1:0]      RST_DIFF_THRESH  = 8'd5;

  localparam logic FUNC_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] window_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_DEAD_LEVEL   = 3'd2,
    REG_HOT_LEVEL    = 3'd3,
    REG_DIFF_THRESH  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DEAD = 2'd1,
    KIND_HOT  = 2'd2
  } defect_kind_t;

  // fixed 19 compare-exchange median network
  function automatic pix_t median9(input window_t cells);
    pix_t p [9];
    pix_t t;
    for (int i = 0; i < 9; i++) begin
      p[i] = cells[i];
    end
    if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
    if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
    if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
    if (p[0] > p[1]) begin t = p[0]; p[0] = p[1]; p[1] = t; end
    if (p[3] > p[4]) begin t = p[3]; p[3] = p[4]; p[4] = t; end
    if (p[6] > p[7]) begin t = p[6]; p[6] = p[7]; p[7] = t; end
    if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
    if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
    if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
    if (p[0] > p[3]) begin t = p[0]; p[0] = p[3]; p[3] = t; end
    if (p[5] > p[8]) begin t = p[5]; p[5] = p[8]; p[8] = t; end
    if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
    if (p[3] > p[6]) begin t = p[3]; p[3] = p[6]; p[6] = t; end
    if (p[1] > p[4]) begin t = p[1]; p[1] = p[4]; p[4] = t; end
    if (p[2] > p[5]) begin t = p[2]; p[2] = p[5]; p[5] = t; end
    if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
    if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
    if (p[6] > p[4]) begin t = p[6]; p[6] = p[4]; p[4] = t; end
    if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
    return p[4];
  endfunction

endpackage

/* hdl/defect_pixel_median_correct_core.sv */
// defect_pixel_median_correct_core: defect pixel correction with a 3x3 median
// on an 8-bit gray raster stream. Depends on dpmc_pkg.
//
// Usage: pixels enter on the in_ channel (in_func 0 carries in_pixel_in,
// in_func 1 drains one held pixel). Results leave on the out_ channel with the
// pixel, its defect kind, its column, row and a last-of-frame flag. The first
// frame width + 1 pixels after reset or a geometry write give no result; after
// that each pixel item gives the result one line plus one pixel behind it.
// Configuration is written on the cfg_ channel (always ready) while idle;
// writing the width or height restarts the stream.
// Path: an item goes through the line store stage, decision stage and result
// register to out_valid. Throughput: one item per cycle when not stalled, set
// by the single read and write port of each line store, used once per item.
// Reset: geometry and levels take their defaults, counters and window clear,
// the line stores stay unwritten; no clearing pass.
// Stall: while out_valid is high and out_stall is high the whole pipeline
// holds and in_stall is high; otherwise an item is taken every cycle.
module defect_pixel_median_correct_core #(
  parameter int MAX_WIDTH  = dpmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dpmc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [dpmc_pkg::PIX_W-1:0]        in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dpmc_pkg::PIX_W-1:0]        out_pixel_out,
  output logic [1:0]                        out_defect_kind,
  output logic [dpmc_pkg::COORD_W-1:0]      out_col,
  output logic [dpmc_pkg::COORD_W-1:0]      out_row,
  output logic                              out_last_of_frame,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dpmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dpmc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = RW + 1;

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 < 32'd3) begin
      return WW'(3);
    end else if (v32 > 32'(MAX_WIDTH)) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(v32);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 < 32'd3) begin
      return HW'(3);
    end else if (v32 > 32'(MAX_HEIGHT)) begin
      return HW'(MAX_HEIGHT);
    end
    return HW'(v32);
  endfunction

  // configuration
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;
  pix_t          dead_r, hot_r, thr_r;
  logic          restart;

  // stream counters
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [CW-1:0] emit_col_r, emit_col_nxt;
  logic [RW-1:0] emit_row_r, emit_row_nxt;
  logic [WW-1:0] held_r, held_nxt;

  // line stores
  pix_t upper_mem [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t rd_up_r, rd_mid_r;

  // accept stage
  logic          adv, acc, a_drain, a_emit, held_full, a_inner, a_last;
  logic          a_sel_up, a_fwd;
  pix_t          a_fwd_val;
  logic [WW-1:0] w_m1, lc, d, mid_off;
  logic [CW-1:0] up_raddr, mid_raddr;

  // line store stage
  logic          b_valid_r, b_drain_r, b_emit_r, b_inner_r, b_last_r;
  logic          b_sel_up_r, b_fwd_r;
  pix_t          b_pix_r, b_fwd_val_r, b_value;
  logic [CW-1:0] b_addr_r, b_col_r;
  logic [RW-1:0] b_row_r;
  window_t       window_r, window_nxt;

  // decision stage
  logic          c_valid_r, c_drain_r, c_inner_r, c_last_r;
  pix_t          c_value_r, c_center, c_mean, c_diff, c_pix;
  logic [CW-1:0] c_col_r;
  logic [RW-1:0] c_row_r;
  logic [PIX_W+1:0] c_sum;
  defect_kind_t  c_kind;

  // result register
  logic          out_valid_r;
  pix_t          out_pix_r;
  defect_kind_t  out_kind_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic          out_last_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign acc       = in_valid && adv;
  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                                   cfg_index == REG_FRAME_HEIGHT);

  always_comb begin
    a_drain   = (in_func == FUNC_DRAIN);
    w_m1      = w_r - WW'(1);
    held_full = (held_r >= w_r + WW'(1));
    a_emit    = a_drain ? (held_r != '0) : held_full;
    a_inner   = (emit_col_r != '0) && ({1'b0, emit_col_r} + WW'(1) < w_r) &&
                (emit_row_r != '0) && ({1'b0, emit_row_r} + HW'(1) < h_r);
    a_last    = ({1'b0, emit_col_r} == w_m1) &&
                ({1'b0, emit_row_r} == h_r - HW'(1));

    in_col_nxt   = in_col_r;
    held_nxt     = held_r;
    emit_col_nxt = emit_col_r;
    emit_row_nxt = emit_row_r;
    if (acc) begin
      if (!a_drain) begin
        if ({1'b0, in_col_r} + WW'(1) >= w_r) begin
          in_col_nxt = '0;
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
        if (!held_full) begin
          held_nxt = held_r + WW'(1);
        end
      end else if (held_r != '0) begin
        held_nxt = held_r - WW'(1);
      end
      if (a_emit) begin
        if ({1'b0, emit_col_r} + WW'(1) >= w_r) begin
          emit_col_nxt = '0;
          if ({1'b0, emit_row_r} + HW'(1) >= h_r) begin
            emit_row_nxt = '0;
          end else begin
            emit_row_nxt = emit_row_r + RW'(1);
          end
        end else begin
          emit_col_nxt = emit_col_r + CW'(1);
        end
      end
    end

    // drain: oldest held pixel relative to the last written column
    lc = (in_col_r == '0) ? w_m1 : {1'b0, in_col_r} - WW'(1);
    d  = held_r - WW'(1);
    priority if (d <= lc) begin
      mid_off  = lc - d;
      a_sel_up = 1'b0;
    end else if (d < w_r) begin
      mid_off  = w_r - (d - lc);
      a_sel_up = 1'b0;
    end else begin
      mid_off  = lc;
      a_sel_up = 1'b1;
    end
    up_raddr  = a_drain ? lc[CW-1:0] : in_col_r;
    mid_raddr = a_drain ? mid_off[CW-1:0] : in_col_r;

    // the pixel one stage ahead writes the store in the same cycle
    a_fwd     = b_valid_r && !b_drain_r &&
                ((a_sel_up ? up_raddr : mid_raddr) == b_addr_r);
    a_fwd_val = a_sel_up ? rd_mid_r : b_pix_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_up_r <= upper_mem[up_raddr];
      if (b_valid_r && !b_drain_r) begin
        upper_mem[b_addr_r] <= rd_mid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_mid_r <= middle_mem[mid_raddr];
      if (b_valid_r && !b_drain_r) begin
        middle_mem[b_addr_r] <= b_pix_r;
      end
    end
  end

  always_comb begin
    window_nxt    = window_r;
    window_nxt[0] = window_r[1];
    window_nxt[1] = window_r[2];
    window_nxt[2] = rd_up_r;
    window_nxt[3] = window_r[4];
    window_nxt[4] = window_r[5];
    window_nxt[5] = rd_mid_r;
    window_nxt[6] = window_r[7];
    window_nxt[7] = window_r[8];
    window_nxt[8] = b_pix_r;
    b_value = b_fwd_r ? b_fwd_val_r : (b_sel_up_r ? rd_up_r : rd_mid_r);
  end

  always_comb begin
    c_center = window_r[4];
    c_sum    = (PIX_W + 2)'(window_r[1]) + (PIX_W + 2)'(window_r[3]) +
               (PIX_W + 2)'(window_r[5]) + (PIX_W + 2)'(window_r[7]);
    c_mean   = c_sum[PIX_W+1:2];
    c_diff   = (c_center >= c_mean) ? c_center - c_mean : c_mean - c_center;
    c_kind   = KIND_NONE;
    if (!c_drain_r && c_inner_r && c_diff >= thr_r) begin
      if (c_center <= dead_r) begin
        c_kind = KIND_DEAD;
      end else if (c_center >= hot_r) begin
        c_kind = KIND_HOT;
      end
    end
    if (c_drain_r) begin
      c_pix = c_value_r;
    end else if (c_kind != KIND_NONE) begin
      c_pix = median9(window_r);
    end else begin
      c_pix = c_center;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= clamp_w(RST_FRAME_WIDTH);
      h_r         <= clamp_h(RST_FRAME_HEIGHT);
      dead_r      <= RST_DEAD_LEVEL;
      hot_r       <= RST_HOT_LEVEL;
      thr_r       <= RST_DIFF_THRESH;
      in_col_r    <= '0;
      held_r      <= '0;
      emit_col_r  <= '0;
      emit_row_r  <= '0;
      window_r    <= '0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  w_r    <= clamp_w(cfg_data);
          REG_FRAME_HEIGHT: h_r    <= clamp_h(cfg_data);
          REG_DEAD_LEVEL:   dead_r <= cfg_data[PIX_W-1:0];
          REG_HOT_LEVEL:    hot_r  <= cfg_data[PIX_W-1:0];
          REG_DIFF_THRESH:  thr_r  <= cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        in_col_r   <= '0;
        held_r     <= '0;
        emit_col_r <= '0;
        emit_row_r <= '0;
        window_r   <= '0;
      end else begin
        in_col_r   <= in_col_nxt;
        held_r     <= held_nxt;
        emit_col_r <= emit_col_nxt;
        emit_row_r <= emit_row_nxt;
        if (adv && b_valid_r && !b_drain_r) begin
          window_r <= window_nxt;
        end
      end
      if (adv) begin
        b_valid_r   <= acc;
        c_valid_r   <= b_valid_r && b_emit_r;
        out_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_drain_r   <= a_drain;
      b_emit_r    <= a_emit;
      b_inner_r   <= a_inner;
      b_last_r    <= a_last;
      b_sel_up_r  <= a_sel_up;
      b_fwd_r     <= a_fwd;
      b_fwd_val_r <= a_fwd_val;
      b_pix_r     <= in_pixel_in;
      b_addr_r    <= in_col_r;
      b_col_r     <= emit_col_r;
      b_row_r     <= emit_row_r;

      c_drain_r   <= b_drain_r;
      c_inner_r   <= b_inner_r;
      c_last_r    <= b_last_r;
      c_value_r   <= b_value;
      c_col_r     <= b_col_r;
      c_row_r     <= b_row_r;

      out_pix_r   <= c_pix;
      out_kind_r  <= c_kind;
      out_col_r   <= c_col_r;
      out_row_r   <= c_row_r;
      out_last_r  <= c_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = out_pix_r;
  assign out_defect_kind   = out_kind_r;
  assign out_col           = COORD_W'(out_col_r);
  assign out_row           = COORD_W'(out_row_r);
  assign out_last_of_frame = out_last_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= w_r + WW'(1))
    else $error("held count exceeds line length plus one");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, in_col_r} < w_r) && ({1'b0, emit_col_r} < w_r))
    else $error("column counter beyond frame width");

  a_no_pixel_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !a_drain && b_valid_r && !b_drain_r) |-> (in_col_r != b_addr_r))
    else $error("back to back pixel items hit the same line store entry");

endmodule
